// File: rtl/lsh_pkg.sv
package lsh_pkg;

  // CORDIC iteration count (8..32)
  localparam int CORDIC_STEPS = 16;

  // Datapath widths
  localparam int CW    = 50;  // local-frame coordinates, Q8 units of 1e-7 deg arc
  localparam int AW    = 40;  // angles, 1e-9 deg
  localparam int KW    = 34;  // Q30 factors
  localparam int SPLIT = 25;  // low slice of a coordinate in a split multiply
  localparam int MW    = 60;  // partial products
  localparam int JW    = 86;  // joined product
  localparam int QSH   = 30;  // Q30 shift
  localparam int CMW   = 17;  // lookahead register
  localparam int PW    = 42;  // lookahead scaling product
  localparam int LW    = 25;  // scaled lookahead
  localparam int QB    = 16;  // centidegree quotient bits
  localparam int RW    = 40;  // wrapped angle
  localparam int HW    = 16;  // heading

  localparam logic signed [AW-1:0] DEG90  = 40'sd90000000000;
  localparam logic signed [AW-1:0] DEG180 = 40'sd180000000000;
  localparam logic signed [AW-1:0] DEG360 = 40'sd360000000000;

  localparam logic signed [KW-1:0] KINV_Q30     = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_METER_Q8 = 50'sd23023;
  localparam logic [PW-1:0]        CM_TO_E_Q24  = 42'd15088113;
  localparam logic [PW-1:0]        LOOK_ROUND   = 42'd32768;
  localparam logic [CMW-1:0]       LOOK_RESET_CM = 17'd1000;

  localparam logic [RW-1:0] ANG_PER_CDEG = 40'd10000000;
  localparam logic [QB-1:0] HEAD_WRAP    = 16'd36000;

  // angle / 1e7 = (angle >> 7) / 78125, the latter by reciprocal multiply
  localparam int          DIV_SH     = 7;
  localparam int          RECIP_SH   = 48;
  localparam logic [31:0] CDEG_RECIP = 32'd3602879702;  // ceil(2^48 / 78125)

  localparam logic signed [AW-1:0] ATAN_TAB [32] = '{
    40'sd45000000000, 40'sd26565051177, 40'sd14036243468, 40'sd7125016349,
    40'sd3576334375, 40'sd1789910608, 40'sd895173710, 40'sd447614171,
    40'sd223810500, 40'sd111905677, 40'sd55952892, 40'sd27976453,
    40'sd13988227, 40'sd6994114, 40'sd3497057, 40'sd1748528,
    40'sd874264, 40'sd437132, 40'sd218566, 40'sd109283,
    40'sd54642, 40'sd27321, 40'sd13660, 40'sd6830,
    40'sd3415, 40'sd1708, 40'sd854, 40'sd427,
    40'sd213, 40'sd107, 40'sd53, 40'sd27
  };

  // One CORDIC working set
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] z;
  } cs_t;

  // Everything an item carries down the pipe
  typedef struct packed {
    cs_t                  a;      // main CORDIC lane
    cs_t                  b;      // second lane, mean-latitude cosine
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] dlon;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] gdlon;
    logic signed [CW-1:0] sn;
    logic signed [CW-1:0] sdlon;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] se;
    logic signed [CW-1:0] len;
    logic signed [CW-1:0] along;
    logic signed [CW-1:0] ts;
    logic signed [AW-1:0] theta;
    logic signed [MW-1:0] ph0;
    logic signed [MW-1:0] pl0;
    logic signed [MW-1:0] ph1;
    logic signed [MW-1:0] pl1;
    logic signed [MW-1:0] ph2;
    logic signed [MW-1:0] pl2;
    logic                 short_leg;
    logic                 past_goal;
    logic                 zero_vec;
    logic [RW-1:0]        rem;
    logic [QB-1:0]        q;
    logic [HW-1:0]        heading;
  } ctx_t;

endpackage

// File: rtl/lookahead_steering_heading.sv
// Pure-pursuit steering heading. Each transfer on the item channel carries the
// current position, the start of the leg and the goal (1e-7 degree units); one
// heading in centidegrees (0..35999, clockwise from north) comes back per item,
// in order. Positions are projected to a flat frame about the leg start, the
// current position is projected onto the leg, and the heading points at a
// carrot placed lookahead_distance_cm further along the leg (capped at the
// goal). Legs shorter than one meter fall back to the direct bearing to the
// goal. The whole job is one straight pipeline of 5*CORDIC_STEPS+16 register
// stages (96 at 16 steps): five CORDIC passes of one iteration per stage,
// split Q30 multiplies over two stages, and a shift plus reciprocal multiply
// that turns the angle into centidegrees. One item enters per clock while the
// pipe advances; when the result in the output register is not taken, the
// whole pipe holds and item_ready drops. The user must write
// lookahead_distance_cm with lookahead_write only while the pipe is empty;
// the block does not enforce this. It takes effect for the next item.
module lookahead_steering_heading (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 lookahead_write,
  input  logic [16:0]          lookahead_distance_cm,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic signed [30:0]   cur_lat,
  input  logic signed [31:0]   cur_lon,
  input  logic signed [30:0]   leg_start_lat,
  input  logic signed [31:0]   leg_start_lon,
  input  logic signed [30:0]   goal_lat,
  input  logic signed [31:0]   goal_lon,
  output logic                 heading_valid,
  input  logic                 heading_ready,
  output logic [15:0]          heading_centideg
);

  localparam int N = lsh_pkg::CORDIC_STEPS;
  localparam int CW = lsh_pkg::CW;
  localparam int AW = lsh_pkg::AW;
  localparam int KW = lsh_pkg::KW;
  localparam int MW = lsh_pkg::MW;
  localparam int JW = lsh_pkg::JW;
  localparam int SPLIT = lsh_pkg::SPLIT;
  localparam int QB = lsh_pkg::QB;
  localparam int RW = lsh_pkg::RW;

  // Stage map: step t turns register t into register t+1
  localparam int T_M1   = N;          // projection multiplies, partials
  localparam int T_M2   = N + 1;      // projection multiplies, join
  localparam int T_V0   = N + 2;      // leg bearing, quadrant fold
  localparam int T_V    = N + 3;      // leg bearing iterations
  localparam int T_L1   = 2 * N + 3;  // leg length partials, cross-track rotate fold
  localparam int T_L2   = 2 * N + 4;  // leg length join, short-leg test
  localparam int T_R    = 2 * N + 5;  // rotate into the leg frame
  localparam int T_A1   = 3 * N + 5;  // along-track gain removal, partials
  localparam int T_A2   = 3 * N + 6;  // along-track join and clamp
  localparam int T_T    = 3 * N + 7;  // carrot distance
  localparam int T_T1   = 3 * N + 8;  // carrot gain removal, partials
  localparam int T_T2   = 3 * N + 9;  // join, rotate back fold
  localparam int T_R2   = 3 * N + 10; // rotate carrot out of the leg frame
  localparam int T_H0   = 4 * N + 10; // pick steering vector
  localparam int T_H1   = 4 * N + 11; // heading, quadrant fold
  localparam int T_HV   = 4 * N + 12; // heading iterations
  localparam int T_W    = 5 * N + 12; // wrap to 0..360
  localparam int T_D    = 5 * N + 13; // divide by 1e7, reciprocal multiply
  localparam int T_F    = T_D + 1;    // final wrap, zero vector
  localparam int NREG   = T_F + 2;
  localparam int LAST   = NREG - 1;

  // ---------------------------------------------------------------- helpers

  function automatic lsh_pkg::cs_t rot_pre(input lsh_pkg::cs_t s);
    lsh_pkg::cs_t r;
    r = s;
    if (s.z > lsh_pkg::DEG90) begin
      r.x = -s.x;
      r.y = -s.y;
      r.z = s.z - lsh_pkg::DEG180;
    end else if (s.z < -lsh_pkg::DEG90) begin
      r.x = -s.x;
      r.y = -s.y;
      r.z = s.z + lsh_pkg::DEG180;
    end
    return r;
  endfunction

  function automatic lsh_pkg::cs_t rot_it(input lsh_pkg::cs_t s, input int i);
    lsh_pkg::cs_t r;
    r = s;
    if (s.z >= 0) begin
      r.x = s.x - (s.y >>> i);
      r.y = s.y + (s.x >>> i);
      r.z = s.z - lsh_pkg::ATAN_TAB[i[4:0]];
    end else begin
      r.x = s.x + (s.y >>> i);
      r.y = s.y - (s.x >>> i);
      r.z = s.z + lsh_pkg::ATAN_TAB[i[4:0]];
    end
    return r;
  endfunction

  function automatic lsh_pkg::cs_t vec_pre(input lsh_pkg::cs_t s);
    lsh_pkg::cs_t r;
    r = s;
    r.z = '0;
    if (s.x < 0) begin
      if (s.y >= 0) begin
        r.x = s.y;
        r.y = -s.x;
        r.z = lsh_pkg::DEG90;
      end else begin
        r.x = -s.y;
        r.y = s.x;
        r.z = -lsh_pkg::DEG90;
      end
    end
    return r;
  endfunction

  function automatic lsh_pkg::cs_t vec_it(input lsh_pkg::cs_t s, input int i);
    lsh_pkg::cs_t r;
    r = s;
    if (s.y > 0) begin
      r.x = s.x + (s.y >>> i);
      r.y = s.y - (s.x >>> i);
      r.z = s.z + lsh_pkg::ATAN_TAB[i[4:0]];
    end else begin
      r.x = s.x - (s.y >>> i);
      r.y = s.y + (s.x >>> i);
      r.z = s.z - lsh_pkg::ATAN_TAB[i[4:0]];
    end
    return r;
  endfunction

  // Q30 product split as v = vh*2^SPLIT + vl; join gives floor(v*k / 2^30)
  function automatic logic signed [MW-1:0] mq_hi(input logic signed [CW-1:0] v,
                                                 input logic signed [KW-1:0] k);
    logic signed [CW-SPLIT-1:0] vh;
    vh = v[CW-1:SPLIT];
    return MW'(vh) * MW'(k);
  endfunction

  function automatic logic signed [MW-1:0] mq_lo(input logic signed [CW-1:0] v,
                                                 input logic signed [KW-1:0] k);
    logic signed [SPLIT:0] vl;
    vl = {1'b0, v[SPLIT-1:0]};
    return MW'(vl) * MW'(k);
  endfunction

  function automatic logic signed [CW-1:0] mq_join(input logic signed [MW-1:0] ph,
                                                   input logic signed [MW-1:0] pl);
    logic signed [JW-1:0] s;
    s = (JW'(ph) <<< SPLIT) + JW'(pl);
    return CW'(s >>> lsh_pkg::QSH);
  endfunction

  function automatic logic [lsh_pkg::LW-1:0] look_of(input logic [lsh_pkg::CMW-1:0] cm);
    logic [lsh_pkg::PW-1:0] p;
    p = lsh_pkg::PW'(cm) * lsh_pkg::CM_TO_E_Q24 + lsh_pkg::LOOK_ROUND;
    return lsh_pkg::LW'(p >> 16);
  endfunction

  // Input stage: offsets in Q8 and both cosine CORDICs folded into range
  function automatic lsh_pkg::ctx_t entry(input logic signed [30:0] lat,
                                          input logic signed [31:0] lon,
                                          input logic signed [30:0] slat,
                                          input logic signed [31:0] slon,
                                          input logic signed [30:0] glat,
                                          input logic signed [31:0] glon);
    lsh_pkg::ctx_t c;
    lsh_pkg::cs_t  s;
    c = '0;
    c.py    = (CW'(lat) - CW'(slat)) <<< 8;
    c.dlon  = (CW'(lon) - CW'(slon)) <<< 8;
    c.by    = (CW'(glat) - CW'(slat)) <<< 8;
    c.gdlon = (CW'(glon) - CW'(slon)) <<< 8;
    c.sn    = (CW'(glat) - CW'(lat)) <<< 8;
    c.sdlon = (CW'(glon) - CW'(lon)) <<< 8;
    s.x = CW'(lsh_pkg::KINV_Q30);
    s.y = '0;
    s.z = AW'(slat) * AW'(100);
    c.a = rot_pre(s);
    s.z = (AW'(lat) + AW'(glat)) * AW'(50);
    c.b = rot_pre(s);
    return c;
  endfunction

  function automatic lsh_pkg::ctx_t step(input int t, input lsh_pkg::ctx_t c,
                                         input logic signed [CW-1:0] look);
    lsh_pkg::ctx_t r;
    lsh_pkg::cs_t  s;
    logic signed [AW-1:0] zz;
    logic [31:0] u;
    logic [63:0] prod;
    r = c;
    s = c.a;
    zz = '0;
    u = '0;
    prod = '0;
    if (t < T_M1) begin
      r.a = rot_it(c.a, t);
      r.b = rot_it(c.b, t);
    end else if (t == T_M1) begin
      r.ph0 = mq_hi(c.dlon, KW'(c.a.x));
      r.pl0 = mq_lo(c.dlon, KW'(c.a.x));
      r.ph1 = mq_hi(c.gdlon, KW'(c.a.x));
      r.pl1 = mq_lo(c.gdlon, KW'(c.a.x));
      r.ph2 = mq_hi(c.sdlon, KW'(c.b.x));
      r.pl2 = mq_lo(c.sdlon, KW'(c.b.x));
    end else if (t == T_M2) begin
      r.px = mq_join(c.ph0, c.pl0);
      r.bx = mq_join(c.ph1, c.pl1);
      r.se = mq_join(c.ph2, c.pl2);
    end else if (t == T_V0) begin
      s.x = c.by;
      s.y = c.bx;
      s.z = '0;
      r.a = vec_pre(s);
    end else if (t < T_L1) begin
      r.a = vec_it(c.a, t - T_V);
    end else if (t == T_L1) begin
      r.theta = c.a.z;
      r.ph0 = mq_hi(c.a.x, lsh_pkg::KINV_Q30);
      r.pl0 = mq_lo(c.a.x, lsh_pkg::KINV_Q30);
      s.x = c.py;
      s.y = c.px;
      s.z = -c.a.z;
      r.a = rot_pre(s);
    end else if (t == T_L2) begin
      r.len = mq_join(c.ph0, c.pl0);
      r.short_leg = (c.by == 0 && c.bx == 0) || (r.len < lsh_pkg::ONE_METER_Q8);
    end else if (t < T_A1) begin
      r.a = rot_it(c.a, t - T_R);
    end else if (t == T_A1) begin
      r.ph0 = mq_hi(c.a.x, lsh_pkg::KINV_Q30);
      r.pl0 = mq_lo(c.a.x, lsh_pkg::KINV_Q30);
    end else if (t == T_A2) begin
      r.along = mq_join(c.ph0, c.pl0);
      if (r.along < 0) begin
        r.along = '0;
      end
      if (r.along > c.len) begin
        r.along = c.len;
      end
    end else if (t == T_T) begin
      r.ts = c.along + look;
      r.past_goal = (r.ts >= c.len);
    end else if (t == T_T1) begin
      r.ph0 = mq_hi(c.ts, lsh_pkg::KINV_Q30);
      r.pl0 = mq_lo(c.ts, lsh_pkg::KINV_Q30);
    end else if (t == T_T2) begin
      s.x = mq_join(c.ph0, c.pl0);
      s.y = '0;
      s.z = c.theta;
      r.a = rot_pre(s);
    end else if (t < T_H0) begin
      r.a = rot_it(c.a, t - T_R2);
    end else if (t == T_H0) begin
      if (c.short_leg) begin
        r.a.x = c.sn;
        r.a.y = c.se;
      end else if (c.past_goal) begin
        r.a.x = c.by - c.py;
        r.a.y = c.bx - c.px;
      end else begin
        r.a.x = c.a.x - c.py;
        r.a.y = c.a.y - c.px;
      end
      r.zero_vec = (r.a.x == 0) && (r.a.y == 0);
    end else if (t == T_H1) begin
      r.a = vec_pre(c.a);
    end else if (t < T_W) begin
      r.a = vec_it(c.a, t - T_HV);
    end else if (t == T_W) begin
      zz = c.a.z;
      if (zz < 0) begin
        zz = zz + lsh_pkg::DEG360;
      end
      if (zz < 0) begin
        zz = '0;
      end
      r.rem = RW'($unsigned(zz));
      r.q = '0;
    end else if (t == T_D) begin
      // angle < 2^39, so the shifted value fits 32 bits and the quotient is exact
      u = 32'(c.rem >> lsh_pkg::DIV_SH);
      prod = 64'(u) * 64'(lsh_pkg::CDEG_RECIP);
      r.q = QB'(prod >> lsh_pkg::RECIP_SH);
    end else begin
      if (c.zero_vec) begin
        r.heading = '0;
      end else if (c.q >= lsh_pkg::HEAD_WRAP) begin
        r.heading = c.q - lsh_pkg::HEAD_WRAP;
      end else begin
        r.heading = c.q;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- pipe

  logic [lsh_pkg::LW-1:0] look;
  logic signed [CW-1:0]   look_s;
  logic                   adv;
  logic [NREG-1:0]        vld;
  lsh_pkg::ctx_t          pipe [NREG];
  lsh_pkg::ctx_t          nxt  [NREG];

  // scaled lookahead kept ready for the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      look <= look_of(lsh_pkg::LOOK_RESET_CM);
    end else if (lookahead_write) begin
      look <= look_of(lookahead_distance_cm);
    end
  end

  assign look_s = $signed(CW'(look));

  // the whole pipe moves unless the output register is full and not taken
  assign adv        = !vld[LAST] || heading_ready;
  assign item_ready = adv && !rst;

  assign nxt[0] = entry(cur_lat, cur_lon, leg_start_lat, leg_start_lon, goal_lat, goal_lon);

  for (genvar g = 0; g < NREG - 1; g++) begin : g_stage
    assign nxt[g + 1] = step(g, pipe[g], look_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NREG-2:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe <= nxt;
    end
  end

  assign heading_valid    = vld[LAST];
  assign heading_centideg = pipe[LAST].heading;

`ifndef SYNTHESIS
  a_range: assert property (@(posedge clk) disable iff (rst)
    heading_valid |-> heading_centideg < lsh_pkg::HEAD_WRAP)
    else $error("heading out of range");

  a_reset: assert property (@(posedge clk)
    rst |=> !heading_valid)
    else $error("result valid right after reset");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    vld[T_A2 + 1] |-> (pipe[T_A2 + 1].along >= 0) &&
                      (pipe[T_A2 + 1].along <= pipe[T_A2 + 1].len))
    else $error("along-track not clamped to leg");

  a_rem: assert property (@(posedge clk) disable iff (rst)
    vld[LAST] |-> (RW'(pipe[LAST].q) * lsh_pkg::ANG_PER_CDEG <= pipe[LAST].rem) &&
                  (pipe[LAST].rem < RW'(pipe[LAST].q) * lsh_pkg::ANG_PER_CDEG +
                                    lsh_pkg::ANG_PER_CDEG))
    else $error("centidegree quotient off by a step");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipe moved while stalled");
`endif

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // ------------------------------------------------------------------
  // Clock, reset, DUT hookup
  // ------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  logic                 lookahead_write = 1'b0;
  logic [16:0]          lookahead_distance_cm = '0;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  logic signed [30:0]   cur_lat = '0;
  logic signed [31:0]   cur_lon = '0;
  logic signed [30:0]   leg_start_lat = '0;
  logic signed [31:0]   leg_start_lon = '0;
  logic signed [30:0]   goal_lat = '0;
  logic signed [31:0]   goal_lon = '0;
  logic                 heading_valid;
  logic                 heading_ready = 1'b0;
  logic [15:0]          heading_centideg;

  lookahead_steering_heading i_dut (
    .clk                   (clk),
    .rst                   (rst),
    .lookahead_write       (lookahead_write),
    .lookahead_distance_cm (lookahead_distance_cm),
    .item_valid            (item_valid),
    .item_ready            (item_ready),
    .cur_lat               (cur_lat),
    .cur_lon               (cur_lon),
    .leg_start_lat         (leg_start_lat),
    .leg_start_lon         (leg_start_lon),
    .goal_lat              (goal_lat),
    .goal_lon              (goal_lon),
    .heading_valid         (heading_valid),
    .heading_ready         (heading_ready),
    .heading_centideg      (heading_centideg)
  );

  // Pipe is 5*steps+16 deep; drain margin before touching the register.
  localparam int DRAIN_CYCLES = 5 * lsh_pkg::CORDIC_STEPS + 16 + 20;

  // One entry of the stimulus list: either a fix triple or a register write.
  typedef struct {
    bit                 is_cfg;
    logic [16:0]        look_val;
    logic signed [30:0] clat;
    logic signed [31:0] clon;
    logic signed [30:0] slat;
    logic signed [31:0] slon;
    logic signed [30:0] glat;
    logic signed [31:0] glon;
  } job_t;

  job_t        pending_jobs[$];
  logic [15:0] heading_expected[$];
  logic [16:0] look_cm_model = lsh_pkg::LOOK_RESET_CM;

  int mismatches = 0;
  int idle_cycles = 0;

  // ------------------------------------------------------------------
  // Heading predictor (fixed-point pure pursuit, 64-bit math)
  // ------------------------------------------------------------------
  function automatic int cordic_iters();
    return (lsh_pkg::CORDIC_STEPS > 32) ? 32 : lsh_pkg::CORDIC_STEPS;
  endfunction

  // floor(v * k / 2^30), split so nothing overflows 64 bits
  function automatic longint q30_scale(longint v, longint k);
    longint hi, lo;
    hi = v >>> 15;
    lo = v - hi * 32768;
    return (hi * k + ((lo * k) >>> 15)) >>> 15;
  endfunction

  // rotation mode: turn (x,y) by z, gain left in
  function automatic void cordic_turn(inout longint x, inout longint y, input longint z);
    longint t, a;
    if (z > longint'(lsh_pkg::DEG90)) begin
      x = -x; y = -y; z = z - longint'(lsh_pkg::DEG180);
    end else if (z < -longint'(lsh_pkg::DEG90)) begin
      x = -x; y = -y; z = z + longint'(lsh_pkg::DEG180);
    end
    for (int i = 0; i < cordic_iters(); i++) begin
      t = x;
      a = lsh_pkg::ATAN_TAB[i];
      if (z >= 0) begin
        x = x - (y >>> i); y = y + (t >>> i); z = z - a;
      end else begin
        x = x + (y >>> i); y = y - (t >>> i); z = z + a;
      end
    end
  endfunction

  // vectoring mode: angle of (x,y), x toward y; mag carries gain
  function automatic longint cordic_angle(input longint x, input longint y,
                                          output longint mag);
    longint z, t, a;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = longint'(lsh_pkg::DEG90);
      end else begin
        x = -y; y = t; z = -longint'(lsh_pkg::DEG90);
      end
    end
    for (int i = 0; i < cordic_iters(); i++) begin
      t = x;
      a = lsh_pkg::ATAN_TAB[i];
      if (y > 0) begin
        x = x + (y >>> i); y = y - (t >>> i); z = z + a;
      end else begin
        x = x - (y >>> i); y = y + (t >>> i); z = z - a;
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic longint cos_fix(longint ang);
    longint x, y;
    x = longint'(lsh_pkg::KINV_Q30);
    y = 0;
    cordic_turn(x, y, ang);
    return x;
  endfunction

  function automatic logic [15:0] bearing_cdeg(longint north, longint east);
    longint m, z, c;
    if (north == 0 && east == 0) return 16'd0;
    z = cordic_angle(north, east, m);
    if (z < 0) z = z + longint'(lsh_pkg::DEG360);
    if (z < 0) z = 0;
    c = z / 64'sd10000000;
    if (c >= 36000) c = c - 36000;
    return c[15:0];
  endfunction

  function automatic logic [15:0] carrot_heading(job_t j, logic [16:0] look_cm);
    longint lat, lon, slat, slon, glat, glon;
    longint cr, px, py, bx, by, mag, theta, len, along, yy, look, ts, cx, cy;
    longint cm, n, e, kinv;
    lat = j.clat;  lon = j.clon;
    slat = j.slat; slon = j.slon;
    glat = j.glat; glon = j.glon;
    kinv = longint'(lsh_pkg::KINV_Q30);

    cr = cos_fix(slat * 100);
    py = (lat - slat) * 256;
    px = q30_scale((lon - slon) * 256, cr);
    by = (glat - slat) * 256;
    bx = q30_scale((glon - slon) * 256, cr);

    theta = cordic_angle(by, bx, mag);
    len = q30_scale(mag, kinv);
    // short leg: straight bearing at the mean latitude
    if ((by == 0 && bx == 0) || len < longint'(lsh_pkg::ONE_METER_Q8)) begin
      cm = cos_fix((lat + glat) * 50);
      n = (glat - lat) * 256;
      e = q30_scale((glon - lon) * 256, cm);
      return bearing_cdeg(n, e);
    end

    along = py;
    yy = px;
    cordic_turn(along, yy, -theta);
    along = q30_scale(along, kinv);
    if (along < 0) along = 0;
    if (along > len) along = len;

    look = (longint'(look_cm) * longint'(lsh_pkg::CM_TO_E_Q24) + 32768) >>> 16;
    ts = along + look;
    if (ts >= len) begin
      cx = bx; cy = by;   // carrot clipped to the goal
    end else begin
      cy = q30_scale(ts, kinv);
      cx = 0;
      cordic_turn(cy, cx, theta);
    end
    return bearing_cdeg(cy - py, cx - px);
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  function automatic longint pick(longint lo, longint hi);
    return lo + longint'($urandom_range(0, 32'(hi - lo)));
  endfunction

  // uniform-ish offset in [-2^k, 2^k)
  function automatic longint span(int k);
    return longint'($urandom & ((32'd1 << (k + 1)) - 1)) - (longint'(1) << k);
  endfunction

  function automatic void add_fix(longint clat, longint clon, longint slat, longint slon,
                                  longint glat, longint glon);
    job_t j;
    j.is_cfg = 1'b0;
    j.look_val = '0;
    j.clat = clat[30:0]; j.clon = clon[31:0];
    j.slat = slat[30:0]; j.slon = slon[31:0];
    j.glat = glat[30:0]; j.glon = glon[31:0];
    pending_jobs.push_back(j);
  endfunction

  function automatic void add_look_write(logic [16:0] v);
    job_t j;
    j = '{default: '0};
    j.is_cfg = 1'b1;
    j.look_val = v;
    pending_jobs.push_back(j);
  endfunction

  // Mostly realistic legs with the vehicle near them; some raw noise.
  function automatic void add_random_fix();
    longint slat, slon, glat, glon, clat, clon;
    int r, kl, kc;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      // raw bit patterns, full field width
      add_fix(longint'($signed($urandom)), longint'($signed($urandom)),
              longint'($signed($urandom)), longint'($signed($urandom)),
              longint'($signed($urandom)), longint'($signed($urandom)));
    end else begin
      slat = pick(-900000000, 900000000);
      slon = pick(-1800000000, 1800000000);
      kl = (r < 25) ? $urandom_range(0, 7) : $urandom_range(6, 22);
      kc = $urandom_range(0, kl + 1);
      glat = slat + span(kl);
      glon = slon + span(kl);
      if (r < 40) begin
        // vehicle somewhere along the leg, with cross-track error
        clat = slat + (glat - slat) * longint'($urandom_range(0, 12)) / 10 + span(kc);
        clon = slon + (glon - slon) * longint'($urandom_range(0, 12)) / 10 + span(kc);
      end else begin
        clat = slat + span(kc);
        clon = slon + span(kc);
      end
      add_fix(clat, clon, slat, slon, glat, glon);
    end
  endfunction

  // ------------------------------------------------------------------
  // Driver: item side and register writes, changes on falling edges
  // ------------------------------------------------------------------
  logic item_taken = 1'b0;
  logic heading_taken = 1'b0;
  int   send_gap = 0;
  int   take_gap = 0;
  bit   send_burst = 1'b0;
  bit   take_burst = 1'b0;
  int   send_cnt = 0;
  int   take_cnt = 0;

  always @(negedge clk) begin
    job_t j;
    logic nxt_valid;
    logic nxt_write;
    nxt_valid = item_valid;
    nxt_write = 1'b0;
    if (!rst) begin
      if (item_valid && item_taken) nxt_valid = 1'b0;
      if (!nxt_valid && !lookahead_write) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_jobs.size() > 0) begin
          j = pending_jobs[0];
          if (j.is_cfg) begin
            // only once the pipe has fully drained
            if (idle_cycles >= DRAIN_CYCLES) begin
              void'(pending_jobs.pop_front());
              lookahead_distance_cm <= j.look_val;
              nxt_write = 1'b1;
            end
          end else begin
            void'(pending_jobs.pop_front());
            cur_lat <= j.clat;       cur_lon <= j.clon;
            leg_start_lat <= j.slat; leg_start_lon <= j.slon;
            goal_lat <= j.glat;      goal_lon <= j.glon;
            nxt_valid = 1'b1;
            send_cnt++;
            if (send_cnt % 64 == 0) send_burst = ~send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, 7);
          end
        end
      end
    end
    item_valid <= nxt_valid;
    lookahead_write <= nxt_write;
  end

  // Result side back-pressure: a random stall after each taken result, with bursts of none
  always @(negedge clk) begin
    logic nxt_ready;
    nxt_ready = heading_ready;
    if (!rst) begin
      if (heading_taken) begin
        take_cnt++;
        if (take_cnt % 80 == 0) take_burst = ~take_burst;
        take_gap = take_burst ? 0 : $urandom_range(0, 7);
      end
      if (take_gap > 0) begin
        nxt_ready = 1'b0;
        take_gap--;
      end else begin
        nxt_ready = 1'b1;
      end
    end
    heading_ready <= nxt_ready;
  end

  // ------------------------------------------------------------------
  // Monitor: predict on input transfer, check on output transfer
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    job_t        j;
    logic [15:0] want;
    item_taken <= item_valid && item_ready;
    heading_taken <= heading_valid && heading_ready;
    if (!rst) begin
      if (heading_valid && heading_ready) begin
        if (heading_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected heading %0d at %0t", heading_centideg, $realtime);
        end else begin
          want = heading_expected.pop_front();
          if (heading_centideg !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("heading mismatch: expected %0d actual %0d at %0t",
                       want, heading_centideg, $realtime);
          end
        end
      end
      if (item_valid && item_ready) begin
        j.is_cfg = 1'b0;
        j.look_val = '0;
        j.clat = cur_lat;       j.clon = cur_lon;
        j.slat = leg_start_lat; j.slon = leg_start_lon;
        j.glat = goal_lat;      j.glon = goal_lon;
        heading_expected.push_back(carrot_heading(j, look_cm_model));
      end
      if (lookahead_write) look_cm_model <= lookahead_distance_cm;
      if (heading_expected.size() == 0 && !item_valid) idle_cycles <= idle_cycles + 1;
      else idle_cycles <= 0;
    end
  end

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    logic [16:0] looks[5];
    looks = '{17'd0, 17'h1FFFF, 17'd100000, 17'd1, 17'd0};
    looks[4] = 17'($urandom_range(0, 100000));

    // directed: field extremes, short leg, zero vector, polar overshoot, goal clipping
    add_fix(0, 0, 0, 0, 0, 0);                                    // all zero
    add_fix(100, 100, 0, 0, 0, 0);                                // zero-length leg
    add_fix(5, 5, 0, 0, 50, 50);                                  // under one meter
    add_fix(500000, 500000, 0, 0, 500000, 500000);                // at goal: zero vector
    add_fix(0, 0, 0, 0, 1000000, 0);                              // due north
    add_fix(0, 0, 0, 0, -1000000, 0);                             // due south
    add_fix(0, 0, 0, 0, 0, 1000000);                              // due east
    add_fix(0, 0, 0, 0, 0, -1000000);                             // due west
    add_fix(-50000, 20000, 0, 0, 1000000, 0);                     // behind leg start
    add_fix(2000000, -3000, 0, 0, 1000000, 0);                    // past goal
    add_fix(900000000, 1800000000, 900000000, 1800000000,
            -900000000, -1800000000);                             // range corners
    add_fix(-900000000, -1800000000, -900000000, -1800000000,
            900000000, 1800000000);
    add_fix(1073741823, 2147483647, -1073741824, -2147483648,
            1073741823, 2147483647);                              // full field extremes
    add_fix(-1073741824, -2147483648, 1073741823, 2147483647,
            -1073741824, -2147483648);
    add_fix(1000000000, 0, 1000000000, 0, 1000300000, 200000);    // beyond the pole
    add_fix(-1050000000, 10, -1050000000, 0, -1050100000, 40000);
    add_fix(899990000, 1799990000, 899990000, -1799990000,
            899995000, 1799999999);                               // dateline wrap
    add_fix(10, 10, 0, 0, 3, 4);
    add_fix(123456, -654321, 123400, -654300, 124000, -650000);

    for (int i = 0; i < 185; i++) add_random_fix();
    for (int p = 0; p < 5; p++) begin
      add_look_write(looks[p]);
      for (int i = 0; i < 205; i++) add_random_fix();
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_jobs.size() != 0 || item_valid || heading_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && heading_expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
rtl/lsh_pkg.sv
rtl/lookahead_steering_heading.sv
test/testbench.sv
